// ----- rtl/lsg_pkg.sv -----
// shared types, codes and helpers for the lfo shape generator
`default_nettype none
package lsg_pkg;

    localparam logic [3:0] SHP_TRI   = 4'd0;
    localparam logic [3:0] SHP_SAWU  = 4'd1;
    localparam logic [3:0] SHP_SAWD  = 4'd2;
    localparam logic [3:0] SHP_SQR   = 4'd3;
    localparam logic [3:0] SHP_DECAY = 4'd4;
    localparam logic [3:0] SHP_RND   = 4'd5;
    localparam logic [3:0] SHP_BRN   = 4'd6;
    localparam logic [3:0] SHP_WND   = 4'd7;
    localparam logic [3:0] SHP_FLOW  = 4'd8;

    localparam logic [1:0] TM_CURRENT = 2'd1;
    localparam logic [1:0] TM_NEXT    = 2'd2;

    localparam logic [2:0] CFG_SHAPE  = 3'd0;
    localparam logic [2:0] CFG_BIAS   = 3'd1;
    localparam logic [2:0] CFG_RAMP   = 3'd2;
    localparam logic [2:0] CFG_CYCLES = 3'd3;
    localparam logic [2:0] CFG_TMODE  = 3'd4;
    localparam logic [2:0] CFG_TVALUE = 3'd5;
    localparam logic [2:0] CFG_START  = 3'd6;
    localparam logic [2:0] CFG_DELAY  = 3'd7;

    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_LP1, CMD_LP2, CMD_LP3, CMD_NOTE, CMD_HOLD,
        CMD_DELAY, CMD_ADV, CMD_TERM, CMD_DRAW, CMD_MUL1, CMD_MUL2, CMD_SHAPE,
        CMD_RMUL, CMD_DIVI, CMD_DIVS, CMD_DIVE, CMD_FIN, CMD_EMIT
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_LP1, S_LP2, S_LP3, S_NOTE, S_HOLD, S_DELAY, S_ADV,
        S_DECIDE, S_TERM, S_DRAW, S_MUL1, S_MUL2, S_SHAPE, S_RMUL, S_DIVI,
        S_DIVS, S_DIVE, S_FIN, S_EMIT
    } t_state;

    typedef struct packed {
        logic is_note;
        logic held;
        logic delay_hold;
        logic term;
        logic wrap;
        logic lp_note;
        logic lp_draw;
        logic draw;
        logic ramp_on;
        logic div_last;
        logic out_busy;
    } t_status;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lfo_shape_generator.sv -----
// top level of the low-frequency oscillator shape generator
//
// channel   dir  beat contents
// s_axis    in   tuser: action; tdata: phase_step[23:0], noise_sample[39:24]
// m_axis    out  tuser: one_shot_done; tdata: lfo_value[15:0]
// cfg       in   i_cfg_we, i_cfg_idx register index, i_cfg_data value
//
// one beat at a time; a tick under the fade-in ramp also runs the
// 32-step serial divider
// the shared 27x27 multiplier is used once per cycle in the lowpass, shape and ramp steps
// synchronous active-low reset clears the configuration, the oscillator state and the output valid flag
// the input is taken again once the result sits in the output register
`default_nettype none
module lfo_shape_generator
    import lsg_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // phase_step, noise_sample
    input  wire  [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // lfo_value
    output logic [0:0]  m_axis_tuser,   // one_shot_done
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [23:0] i_cfg_data
);

    t_status            w_status;
    t_cmd               w_cmd;
    logic signed [15:0] w_value;
    logic               w_done;

    lsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lsg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_action     (s_axis_tuser[0]),
        .i_phase_step (s_axis_tdata[23:0]),
        .i_noise      ($signed(s_axis_tdata[39:24])),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_value  (w_value),
        .o_out_done   (w_done)
    );

    assign m_axis_tdata    = w_value;
    assign m_axis_tuser[0] = w_done;

endmodule
`default_nettype wire

// ----- rtl/lsg_ctrl.sv -----
// sequencer that steps the datapath through one beat
`default_nettype none
module lsg_ctrl
    import lsg_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_START;
            S_START: begin
                if (i_status.is_note) begin
                    n_state = i_status.lp_note ? S_LP1 : S_NOTE;
                end else if (i_status.held) begin
                    n_state = S_HOLD;
                end else if (i_status.delay_hold) begin
                    n_state = S_DELAY;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_LP1:    n_state = S_LP2;
            S_LP2:    n_state = S_LP3;
            S_LP3:    n_state = i_status.is_note ? S_NOTE : S_DRAW;
            S_NOTE:   n_state = S_EMIT;
            S_HOLD:   n_state = S_EMIT;
            S_DELAY:  n_state = S_MUL1;
            S_ADV:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_status.term) begin
                    n_state = S_TERM;
                end else if (i_status.wrap && i_status.lp_draw) begin
                    n_state = S_LP1;
                end else if (i_status.wrap && i_status.draw) begin
                    n_state = S_DRAW;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_TERM:   n_state = S_EMIT;
            S_DRAW:   n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_SHAPE;
            S_SHAPE:  n_state = i_status.ramp_on ? S_RMUL : S_FIN;
            S_RMUL:   n_state = S_DIVI;
            S_DIVI:   n_state = S_DIVS;
            S_DIVS:   if (i_status.div_last) n_state = S_DIVE;
            S_DIVE:   n_state = S_FIN;
            S_FIN:    n_state = S_EMIT;
            S_EMIT:   if (!i_status.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_LOAD;
            end
            S_LP1:    o_cmd = CMD_LP1;
            S_LP2:    o_cmd = CMD_LP2;
            S_LP3:    o_cmd = CMD_LP3;
            S_NOTE:   o_cmd = CMD_NOTE;
            S_HOLD:   o_cmd = CMD_HOLD;
            S_DELAY:  o_cmd = CMD_DELAY;
            S_ADV:    o_cmd = CMD_ADV;
            S_TERM:   o_cmd = CMD_TERM;
            S_DRAW:   o_cmd = CMD_DRAW;
            S_MUL1:   o_cmd = CMD_MUL1;
            S_MUL2:   o_cmd = CMD_MUL2;
            S_SHAPE:  o_cmd = CMD_SHAPE;
            S_RMUL:   o_cmd = CMD_RMUL;
            S_DIVI:   o_cmd = CMD_DIVI;
            S_DIVS:   o_cmd = CMD_DIVS;
            S_DIVE:   o_cmd = CMD_DIVE;
            S_FIN:    o_cmd = CMD_FIN;
            S_EMIT:   if (!i_status.out_busy) o_cmd = CMD_EMIT;
            default:  o_cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/lsg_dp.sv -----
// oscillator state, shared multiplier, serial divider and output register
`default_nettype none
module lsg_dp
    import lsg_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_action,
    input  wire         [23:0] i_phase_step,
    input  wire  signed [15:0] i_noise,
    input  wire                i_cfg_we,
    input  wire         [2:0]  i_cfg_idx,
    input  wire         [23:0] i_cfg_data,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output logic signed [15:0] o_out_value,
    output logic               o_out_done
);

    logic        [3:0]  r_shape;
    logic signed [15:0] r_bias, r_tval;
    logic        [15:0] r_ramp_ticks, r_dly_ticks;
    logic        [7:0]  r_osc;
    logic        [1:0]  r_tmode;
    logic        [23:0] r_start;

    logic               r_action;
    logic        [23:0] r_step;
    logic signed [15:0] r_noise;

    logic        [23:0] r_phase;
    logic signed [15:0] r_cur, r_next, r_lp, r_held, r_last;
    logic        [15:0] r_ramp_cnt, r_delay;
    logic        [7:0]  r_cyc;
    logic               r_active;

    logic               r_wrap, r_term, r_zero, r_neg;
    logic signed [53:0] r_prod, r_acc;
    logic signed [16:0] r_val;
    logic        [31:0] r_dvd;
    logic        [15:0] r_rem;
    logic        [4:0]  r_dcnt;
    logic signed [15:0] r_res_val;
    logic               r_res_done;
    logic               r_out_valid, r_out_done;
    logic signed [15:0] r_out_val;

    logic        [23:0] w_p;
    logic signed [16:0] w_d;
    logic signed [26:0] w_ma, w_mb;
    logic signed [53:0] w_mprod, w_lpsum, w_lpsh, w_abs;
    logic signed [17:0] w_shape;
    logic        [24:0] w_sum;
    logic        [16:0] w_dsh, w_q;
    logic signed [16:0] w_tsel;

    assign w_p = r_zero ? 24'd0 : r_phase;
    assign w_d = 17'(r_next) - 17'(r_cur);

    always_comb begin
        w_ma = 27'sd0;
        w_mb = 27'sd0;
        case (i_cmd)
            CMD_LP1: begin
                w_ma = 27'(r_noise);
                w_mb = 27'sd26214;
            end
            CMD_LP2: begin
                w_ma = 27'(r_lp);
                w_mb = 27'sd39322;
            end
            CMD_MUL1: begin
                w_ma = $signed({3'b000, w_p});
                w_mb = (r_shape == SHP_DECAY) ? $signed({3'b000, w_p}) : 27'(w_d);
            end
            CMD_MUL2: begin
                w_ma = $signed({3'b000, r_prod[47:24]});
                w_mb = 27'sd50331648 - $signed({2'b00, w_p, 1'b0});
            end
            CMD_RMUL: begin
                w_ma = 27'(r_val);
                w_mb = $signed({11'd0, r_ramp_cnt});
            end
            default: begin
                w_ma = 27'sd0;
                w_mb = 27'sd0;
            end
        endcase
    end

    assign w_mprod = w_ma * w_mb;
    assign w_lpsum = r_acc + r_prod + 54'sd32768;
    assign w_lpsh  = w_lpsum >>> 16;
    assign w_abs   = r_prod[53] ? -r_prod : r_prod;
    assign w_sum   = {1'b0, r_phase} + {1'b0, r_step};
    assign w_dsh   = {r_rem, r_dvd[31]};
    assign w_q     = r_dvd[16:0];

    always_comb begin
        case (r_shape)
            SHP_TRI: begin
                if (!w_p[23]) begin
                    w_shape = $signed({3'b000, w_p[22:8]}) - 18'sd16384;
                end else begin
                    w_shape = 18'sd16384 - $signed({3'b000, w_p[22:8]});
                end
            end
            SHP_SAWU:  w_shape = $signed({3'b000, w_p[23:9]}) - 18'sd16384;
            SHP_SAWD:  w_shape = 18'sd16384 - $signed({3'b000, w_p[23:9]});
            SHP_SQR:   w_shape = w_p[23] ? 18'sd16384 : -18'sd16384;
            SHP_DECAY: w_shape = 18'sd16384 - $signed({1'b0, r_prod[49:33]});
            SHP_RND, SHP_BRN: w_shape = 18'(r_cur);
            SHP_WND, SHP_FLOW: w_shape = 18'(r_cur) + 18'(r_prod[40:24]);
            default:   w_shape = -18'sd16384;
        endcase
    end

    always_comb begin
        case (r_tmode)
            TM_CURRENT: w_tsel = 17'(r_cur);
            TM_NEXT:    w_tsel = 17'(r_next);
            default:    w_tsel = 17'(r_tval);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= 4'd0;
            r_bias <= 16'sd0;
            r_ramp_ticks <= 16'd0;
            r_osc <= 8'd0;
            r_tmode <= 2'd0;
            r_tval <= 16'sd0;
            r_start <= 24'd0;
            r_dly_ticks <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHAPE:  r_shape <= i_cfg_data[3:0];
                CFG_BIAS:   r_bias <= $signed(i_cfg_data[15:0]);
                CFG_RAMP:   r_ramp_ticks <= i_cfg_data[15:0];
                CFG_CYCLES: r_osc <= i_cfg_data[7:0];
                CFG_TMODE:  r_tmode <= i_cfg_data[1:0];
                CFG_TVALUE: r_tval <= $signed(i_cfg_data[15:0]);
                CFG_START:  r_start <= i_cfg_data;
                CFG_DELAY:  r_dly_ticks <= i_cfg_data[15:0];
                default:    r_shape <= r_shape;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 24'd0;
            r_cur <= 16'sd0;
            r_next <= 16'sd0;
            r_lp <= 16'sd0;
            r_held <= 16'sd0;
            r_last <= 16'sd0;
            r_ramp_cnt <= 16'd0;
            r_delay <= 16'd0;
            r_cyc <= 8'd0;
            r_active <= 1'b0;
            r_wrap <= 1'b0;
            r_term <= 1'b0;
            r_zero <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_LP3: r_lp <= sat16(w_lpsh[39:0]);
                CMD_NOTE: begin
                    if (r_dly_ticks != 16'd0) begin
                        r_phase <= 24'd0;
                        r_delay <= r_dly_ticks;
                    end else begin
                        r_phase <= r_start;
                        r_delay <= 16'd0;
                    end
                    if (r_osc != 8'd0) begin
                        r_cyc <= r_osc;
                        r_active <= 1'b1;
                    end
                    r_ramp_cnt <= 16'd0;
                    if (r_shape == SHP_RND) begin
                        r_cur <= r_noise;
                    end else if (r_shape == SHP_BRN || r_shape == SHP_WND
                                 || r_shape == SHP_FLOW) begin
                        r_cur <= r_lp;
                    end
                end
                CMD_HOLD: r_last <= r_held;
                CMD_DELAY: begin
                    r_delay <= r_delay - 16'd1;
                    r_zero <= 1'b1;
                end
                CMD_ADV: begin
                    if (r_delay != 16'd0) r_delay <= r_delay - 16'd1;
                    r_phase <= w_sum[23:0];
                    r_wrap <= w_sum[24];
                    r_zero <= 1'b0;
                    r_term <= w_sum[24] && r_active && (r_cyc <= 8'd1);
                    if (w_sum[24] && r_active) begin
                        if (r_cyc <= 8'd1) begin
                            r_cyc <= 8'd0;
                            r_active <= 1'b0;
                        end else begin
                            r_cyc <= r_cyc - 8'd1;
                        end
                    end
                end
                CMD_TERM: begin
                    r_held <= sat16(40'(w_tsel) + 40'(r_bias));
                    r_last <= sat16(40'(w_tsel) + 40'(r_bias));
                end
                CMD_DRAW: begin
                    case (r_shape)
                        SHP_RND: r_cur <= r_noise;
                        SHP_BRN: r_cur <= r_lp;
                        SHP_WND: begin
                            r_cur <= r_next;
                            r_next <= r_noise;
                        end
                        SHP_FLOW: begin
                            r_cur <= r_next;
                            r_next <= r_lp;
                        end
                        default: r_cur <= r_cur;
                    endcase
                end
                CMD_DIVE: r_ramp_cnt <= r_ramp_cnt + 16'd1;
                CMD_FIN:  r_last <= sat16(40'(r_val) + 40'(r_bias));
                default:  r_zero <= r_zero;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_action <= i_action;
                r_step <= i_phase_step;
                r_noise <= i_noise;
            end
            CMD_LP1: r_prod <= w_mprod;
            CMD_LP2: begin
                r_acc <= r_prod;
                r_prod <= w_mprod;
            end
            CMD_MUL1: r_prod <= w_mprod;
            CMD_MUL2: if (r_shape == SHP_DECAY) r_prod <= w_mprod;
            CMD_SHAPE: r_val <= w_shape[16:0];
            CMD_RMUL: r_prod <= w_mprod;
            CMD_DIVI: begin
                r_dvd <= w_abs[31:0];
                r_neg <= r_prod[53];
                r_rem <= 16'd0;
                r_dcnt <= 5'd0;
            end
            CMD_DIVS: begin
                if (w_dsh >= {1'b0, r_ramp_ticks}) begin
                    r_rem <= 16'(w_dsh - {1'b0, r_ramp_ticks});
                    r_dvd <= {r_dvd[30:0], 1'b1};
                end else begin
                    r_rem <= w_dsh[15:0];
                    r_dvd <= {r_dvd[30:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 5'd1;
            end
            CMD_DIVE: r_val <= r_neg ? -$signed(w_q) : $signed(w_q);
            CMD_NOTE: begin
                r_res_val <= r_last;
                r_res_done <= 1'b0;
            end
            CMD_HOLD: begin
                r_res_val <= r_held;
                r_res_done <= 1'b1;
            end
            CMD_TERM: begin
                r_res_val <= sat16(40'(w_tsel) + 40'(r_bias));
                r_res_done <= 1'b1;
            end
            CMD_FIN: begin
                r_res_val <= sat16(40'(r_val) + 40'(r_bias));
                r_res_done <= 1'b0;
            end
            CMD_EMIT: begin
                r_out_val <= r_res_val;
                r_out_done <= r_res_done;
            end
            default: r_res_done <= r_res_done;
        endcase
    end

    assign o_status.is_note    = r_action;
    assign o_status.held       = (r_osc != 8'd0) && !r_active;
    assign o_status.delay_hold = r_delay > 16'd1;
    assign o_status.term       = r_term;
    assign o_status.wrap       = r_wrap;
    assign o_status.lp_note    = (r_shape == SHP_BRN) || (r_shape == SHP_WND)
                                 || (r_shape == SHP_FLOW);
    assign o_status.lp_draw    = (r_shape == SHP_BRN) || (r_shape == SHP_FLOW);
    assign o_status.draw       = (r_shape == SHP_RND) || (r_shape == SHP_BRN)
                                 || (r_shape == SHP_WND) || (r_shape == SHP_FLOW);
    assign o_status.ramp_on    = !r_zero && (r_ramp_cnt < r_ramp_ticks);
    assign o_status.div_last   = r_dcnt == DIV_LAST;
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_val;
    assign o_out_done  = r_out_done;

`ifndef ASSERT_OFF
    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cyc != 8'd0)) else $error("one-shot active with zero count");
    a_delay_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_delay != 16'd0) |-> (r_phase == 24'd0)) else $error("phase moved during delay");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_DIVE) |-> (r_rem < r_ramp_ticks)) else $error("divider remainder");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_lfo_shape_generator.sv -----
// self-checking testbench for the lfo shape generator: directed beats then random beats
`timescale 1ns / 1ps
`default_nettype none
module tb_lfo_shape_generator
    import lsg_pkg::*;
;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_NOTE = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1000;

    typedef struct packed {
        logic [15:0] value;
        logic        done;
    } t_lfo_out;

    typedef struct {
        logic        act;
        logic [23:0] step;
        logic [15:0] noise;
        logic        typed;
        t_lfo_out    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    lfo_shape_generator dut (.*);

    // configuration copy
    logic [3:0]         c_shape;
    logic signed [15:0] c_bias, c_tval;
    logic [15:0]        c_ramp, c_delay;
    logic [7:0]         c_cycles;
    logic [1:0]         c_tmode;
    logic [23:0]        c_start;
    // oscillator state copy
    logic [23:0]        m_phase;
    logic signed [15:0] m_cur, m_next, m_lp;
    logic [15:0]        m_ramp_cnt, m_delay_rem;
    logic [7:0]         m_cyc_rem;
    logic               m_active;
    logic signed [16:0] m_held, m_last;

    t_lfo_out lfo_expected[$];
    int  errors = 0;
    int  idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [16:0] sat_q14(input longint v);
        if (v > 32767) return 17'sd32767;
        if (v < -32768) return -17'sd32768;
        return v[16:0];
    endfunction

    function automatic longint floor_shr(input longint x, input int n);
        return x >>> n;
    endfunction

    task automatic noise_lowpass_update(input logic signed [15:0] nz);
        longint acc;
        acc = longint'(nz) * 26214 + longint'(m_lp) * 39322 + 32768;
        m_lp = 16'(sat_q14(floor_shr(acc, 16)));
    endtask

    function automatic longint shape_at(input logic [23:0] p);
        longint q, s, d;
        case (c_shape)
            SHP_TRI:   return p < 24'h800000 ? longint'(p >> 8) - 16384
                                             : 16384 - longint'((p - 24'h800000) >> 8);
            SHP_SAWU:  return longint'(p >> 9) - 16384;
            SHP_SAWD:  return 16384 - longint'(p >> 9);
            SHP_SQR:   return p < 24'h800000 ? -16384 : 16384;
            SHP_DECAY: begin
                q = (longint'(p) * longint'(p)) >>> 24;
                s = (q * (3 * 64'd16777216 - 2 * longint'(p))) >>> 24;
                return 16384 - (s >>> 9);
            end
            SHP_RND, SHP_BRN: return m_cur;
            SHP_WND, SHP_FLOW: begin
                d = longint'(m_next) - longint'(m_cur);
                return longint'(m_cur) + floor_shr(longint'(p) * d, 24);
            end
            default: return -16384;
        endcase
    endfunction

    task automatic predict_lfo(input logic act, input logic [23:0] step,
                               input logic signed [15:0] nz, output t_lfo_out r);
        longint v;
        logic [24:0] sum;
        logic wrapped;
        r.done = 1'b0;
        if (act == ACT_NOTE) begin
            if (c_delay > 0) begin
                m_phase = '0;
                m_delay_rem = c_delay;
            end else begin
                m_delay_rem = '0;
                m_phase = c_start;
            end
            if (c_cycles > 0) begin
                m_cyc_rem = c_cycles;
                m_active = 1'b1;
            end
            m_ramp_cnt = '0;
            if (c_shape == SHP_RND) begin
                m_cur = nz;
            end else if (c_shape >= SHP_BRN && c_shape <= SHP_FLOW) begin
                noise_lowpass_update(nz);
                m_cur = m_lp;
            end
            r.value = m_last[15:0];
            return;
        end
        if (c_cycles > 0 && !m_active) begin
            m_last = m_held;
            r.value = m_held[15:0];
            r.done = 1'b1;
            return;
        end
        if (m_delay_rem > 0) begin
            m_delay_rem--;
            if (m_delay_rem > 0) begin
                m_last = sat_q14(shape_at(24'd0) + c_bias);
                r.value = m_last[15:0];
                return;
            end
        end
        sum = {1'b0, m_phase} + {1'b0, step};
        wrapped = sum[24];
        m_phase = sum[23:0];
        if (wrapped && m_active) begin
            if (m_cyc_rem <= 1) begin
                m_cyc_rem = '0;
                m_active = 1'b0;
                if (c_tmode == TM_CURRENT) v = m_cur;
                else if (c_tmode == TM_NEXT) v = m_next;
                else v = c_tval;
                m_held = sat_q14(v + c_bias);
                m_last = m_held;
                r.value = m_held[15:0];
                r.done = 1'b1;
                return;
            end
            m_cyc_rem--;
        end
        if (wrapped) begin
            case (c_shape)
                SHP_RND: m_cur = nz;
                SHP_BRN: begin
                    noise_lowpass_update(nz);
                    m_cur = m_lp;
                end
                SHP_WND: begin
                    m_cur = m_next;
                    m_next = nz;
                end
                SHP_FLOW: begin
                    noise_lowpass_update(nz);
                    m_cur = m_next;
                    m_next = m_lp;
                end
                default: ;
            endcase
        end
        v = shape_at(m_phase);
        if (m_ramp_cnt < c_ramp) begin
            v = (v * longint'(m_ramp_cnt)) / longint'(c_ramp);
            m_ramp_cnt++;
        end
        m_last = sat_q14(v + c_bias);
        r.value = m_last[15:0];
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SHAPE:  c_shape  = val[3:0];
            CFG_BIAS:   c_bias   = val[15:0];
            CFG_RAMP:   c_ramp   = val[15:0];
            CFG_CYCLES: c_cycles = val[7:0];
            CFG_TMODE:  c_tmode  = val[1:0];
            CFG_TVALUE: c_tval   = val[15:0];
            CFG_START:  c_start  = val;
            CFG_DELAY:  c_delay  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (lfo_expected.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic act, input logic [23:0] step,
                             input logic [15:0] nz, input bit typed, input t_lfo_out want);
        t_lfo_out r;
        int n_wait;
        n_wait = $urandom_range(0, 9);
        if (n_wait != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n_wait) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {nz, step};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_lfo(act, step, nz, r);
        if (typed && r.value !== want.value) begin
            $error("table lfo_value expected %0d actual %0d",
                   $signed(want.value), $signed(r.value));
            errors++;
        end
        if (typed && r.done !== want.done) begin
            $error("table one_shot_done expected %0d actual %0d", want.done, r.done);
            errors++;
        end
        lfo_expected.push_back(r);
    endtask

    function automatic logic [15:0] rand_noise;
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hc000;
            3: return 16'h4000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_step;
        case ($urandom_range(0, 5))
            0: return 24'hffffff;
            1: return 24'd0;
            2: return 24'($urandom_range(0, 24'h3fffff));
            default: return 24'($urandom);
        endcase
    endfunction

    // output side: random stall per beat, compare
    initial begin
        t_lfo_out got, want;
        int n_wait;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n_wait = $urandom_range(0, 9);
            if (n_wait != 0) begin
                m_axis_tready <= 1'b0;
                repeat (n_wait) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.value = m_axis_tdata;
            got.done  = m_axis_tuser[0];
            if (lfo_expected.size() == 0) begin
                $error("unexpected beat: lfo_value %0d", $signed(got.value));
                errors++;
            end else begin
                want = lfo_expected.pop_front();
                if (got.value !== want.value) begin
                    $error("lfo_value expected %0d actual %0d",
                           $signed(want.value), $signed(got.value));
                    errors++;
                end
                if (got.done !== want.done) begin
                    $error("one_shot_done expected %0d actual %0d", want.done, got.done);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_lfo_out none;
        none = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        {c_shape, c_bias, c_ramp, c_cycles, c_tmode, c_tval, c_start, c_delay} = '0;
        {m_phase, m_cur, m_next, m_lp, m_ramp_cnt, m_delay_rem} = '0;
        {m_cyc_rem, m_active, m_held, m_last} = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: tri at phase zero, then extreme steps
        rows.push_back('{ACT_TICK, 24'd0, 16'h0000, 1'b1, '{16'hc000, 1'b0}});
        rows.push_back('{ACT_NOTE, 24'd0, 16'h0000, 1'b1, '{16'hc000, 1'b0}});
        rows.push_back('{ACT_TICK, 24'h800000, 16'h7fff, 1'b1, '{16'h4000, 1'b0}});
        rows.push_back('{ACT_TICK, 24'hffffff, 16'h8000, 1'b0, none});
        rows.push_back('{ACT_TICK, 24'h7fffff, 16'h4000, 1'b0, none});
        foreach (rows[i]) send_beat(rows[i].act, rows[i].step, rows[i].noise,
                                   rows[i].typed, rows[i].want);
        wait_drained();

        // each shape plus unused code, with saturating bias
        for (int s = 0; s <= 9; s++) begin
            write_reg(CFG_SHAPE, 24'(s == 9 ? 15 : s));
            write_reg(CFG_BIAS, s[0] ? 24'h004000 : 24'h00c000);
            send_beat(ACT_NOTE, 24'd0, 16'h7fff, 0, none);
            send_beat(ACT_TICK, 24'hc00000, 16'h8000, 0, none);
            send_beat(ACT_TICK, 24'h500000, 16'h1234, 0, none);
            wait_drained();
        end
        // one-shot end, terminal mode three, ramp, delay, start phase
        write_reg(CFG_CYCLES, 24'd1);
        write_reg(CFG_TVALUE, 24'h004000);
        write_reg(CFG_TMODE, 24'd3);
        write_reg(CFG_RAMP, 24'd3);
        write_reg(CFG_START, 24'hffffff);
        write_reg(CFG_DELAY, 24'd2);
        send_beat(ACT_TICK, 24'd5, 16'h0, 0, none);
        send_beat(ACT_NOTE, 24'd0, 16'h0, 0, none);
        send_beat(ACT_TICK, 24'hffffff, 16'h0, 0, none);
        send_beat(ACT_TICK, 24'hffffff, 16'h0, 0, none);
        send_beat(ACT_TICK, 24'hffffff, 16'h0, 0, none);
        send_beat(ACT_TICK, 24'hffffff, 16'h0, 0, none);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_SHAPE, 24'($urandom_range(0, 15) < 13 ? $urandom_range(0, 8)
                                                                : $urandom_range(9, 15)));
            write_reg(CFG_BIAS, 24'(16'($urandom_range(0, 32768) - 16384)));
            write_reg(CFG_RAMP, ph == 3 ? 24'd65535 : 24'($urandom_range(0, 6)));
            write_reg(CFG_CYCLES, ph == 2 ? 24'd255 : 24'($urandom_range(0, 4)));
            write_reg(CFG_TMODE, 24'($urandom_range(0, 3)));
            write_reg(CFG_TVALUE, ph == 1 ? 24'h00c000 : 24'(16'($urandom)));
            write_reg(CFG_START, 24'($urandom));
            write_reg(CFG_DELAY, ph == 3 ? 24'd65535 : 24'($urandom_range(0, 3)));
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                if (k == N_RANDOM / 8) wait_drained();
                send_beat($urandom_range(0, 15) == 0 ? ACT_NOTE : ACT_TICK,
                          rand_step(), rand_noise(), 0, none);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
